// File: rtl/icpf_pkg.sv
// shared types and constants of the image chunk packet framer
`timescale 1ns / 1ps

package icpf_pkg;

  // payload bytes in one data packet and the largest image accepted
  localparam int CHUNK_BYTES     = 240;
  localparam int MAX_IMAGE_BYTES = 65536;

  // chunk count by reciprocal multiply, exact for numerators below 2**18
  localparam int NUMER_W   = 18;
  localparam int CNT_SHIFT = 26;
  localparam int RECIP_W   = 27;
  localparam int PROD_W    = NUMER_W + RECIP_W;
  localparam logic [RECIP_W-1:0] CNT_RECIP =
    RECIP_W'(((64'd1 << CNT_SHIFT) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES));

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // packet type bytes
  localparam logic [7:0] TYPE_HEADER = 8'hA1;
  localparam logic [7:0] TYPE_DATA   = 8'hA2;
  localparam logic [7:0] TYPE_TAIL   = 8'hA3;

  // request action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_TAIL   = 2'd2
  } kind_e;

  // one classified request waiting for the back part
  typedef struct packed {
    logic        is_start;    // header command, else one data byte
    logic        open_chunk;  // data byte opens a new chunk: preamble first
    logic        eop;         // data byte closes its data packet
    logic        final_run;   // a tail packet follows
    logic [7:0]  data;        // image byte
    logic [16:0] length;      // image length for header and tail
    logic [15:0] number;      // chunk count on start, chunk index on data
  } cmd_t;

endpackage

// File: rtl/icpf_front.sv
// front part: accepts requests, tracks the image and classifies each byte
`timescale 1ns / 1ps

module icpf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               action_i,
  input  logic [16:0]        image_length_i,
  input  logic [7:0]         data_byte_i,
  input  logic               full_i,
  output logic               in_stall_o,
  output logic               push_o,
  output icpf_pkg::cmd_t     cmd_o
);
  import icpf_pkg::*;

  logic                 active_q, active_d;
  logic [16:0]          length_q, length_d;
  logic [16:0]          bytes_q, bytes_d;
  logic [15:0]          index_q, index_d;
  logic [7:0]           pos_q, pos_d;

  logic                 accept;
  logic [NUMER_W-1:0]   numer;
  logic [PROD_W-1:0]    prod;
  logic [15:0]          chunks;
  logic                 too_long;
  logic [16:0]          bytes_inc;
  logic [7:0]           pos_inc;
  logic                 final_byte;
  logic                 chunk_full;

  // queue full holds the source off
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // ceil(length / chunk) through a constant reciprocal
  assign numer    = NUMER_W'(image_length_i) + NUMER_W'(CHUNK_BYTES - 1);
  assign prod     = PROD_W'(numer) * PROD_W'(CNT_RECIP);
  assign chunks   = prod[CNT_SHIFT +: 16];
  assign too_long = 32'(image_length_i) > MAX_IMAGE_BYTES;

  // position of this byte in image and chunk
  assign bytes_inc  = bytes_q + 17'd1;
  assign pos_inc    = pos_q + 8'd1;
  assign final_byte = bytes_inc == length_q;
  assign chunk_full = pos_inc >= 8'(CHUNK_BYTES);

  // classify the request and update the image state
  always_comb begin
    active_d = active_q;
    length_d = length_q;
    bytes_d  = bytes_q;
    index_d  = index_q;
    pos_d    = pos_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    if (accept) begin
      if (action_i == ACT_START) begin
        if (!too_long) begin
          push_o           = 1'b1;
          cmd_o.is_start   = 1'b1;
          cmd_o.final_run  = image_length_i == 17'd0;
          cmd_o.length     = image_length_i;
          cmd_o.number     = chunks;
          active_d         = image_length_i != 17'd0;
          length_d         = image_length_i;
          bytes_d          = '0;
          index_d          = '0;
          pos_d            = '0;
        end
      end else if (active_q) begin
        push_o           = 1'b1;
        cmd_o.open_chunk = pos_q == 8'd0;
        cmd_o.eop        = final_byte || chunk_full;
        cmd_o.final_run  = final_byte;
        cmd_o.data       = data_byte_i;
        cmd_o.length     = length_q;
        cmd_o.number     = index_q;
        bytes_d          = bytes_inc;
        pos_d            = pos_inc;
        if (chunk_full) begin
          pos_d   = '0;
          index_d = index_q + 16'd1;
        end
        if (final_byte) begin
          active_d = 1'b0;
        end
      end
    end
  end

  // image state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      length_q <= '0;
      bytes_q  <= '0;
      index_q  <= '0;
      pos_q    <= '0;
    end else begin
      active_q <= active_d;
      length_q <= length_d;
      bytes_q  <= bytes_d;
      index_q  <= index_d;
      pos_q    <= pos_d;
    end
  end

endmodule

// File: rtl/icpf_fifo.sv
// short command queue between the front and the back part
`timescale 1ns / 1ps

module icpf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  icpf_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output icpf_pkg::cmd_t  head_o,
  output logic            full_o,
  output logic            empty_o
);
  import icpf_pkg::*;

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q, count_d;

  assign full_o  = count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  // fill level
  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + (QUEUE_PTR_W+1)'(1);
      2'b01:   count_d = count_q - (QUEUE_PTR_W+1)'(1);
      default: count_d = count_q;
    endcase
  end

  // pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/icpf_back.sv
// back part: expands each command into packet bytes, one per cycle while the output is not stalled
`timescale 1ns / 1ps

module icpf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  icpf_pkg::cmd_t  head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      packet_kind_o,
  output logic            end_of_packet_o,
  output logic            last_of_run_o
);
  import icpf_pkg::*;

  typedef enum logic [3:0] {
    SEG_HDR  = 4'b0001,
    SEG_PRE  = 4'b0010,
    SEG_DAT  = 4'b0100,
    SEG_TAIL = 4'b1000
  } seg_e;

  logic        busy_q, busy_d;
  seg_e        seg_q, seg_d;
  logic [2:0]  pos_q, pos_d;
  cmd_t        cmd_q, cmd_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  kind_e       out_kind_q;
  logic        out_eop_q;
  logic        out_last_q;

  logic        out_ready;
  logic        produce;
  logic [31:0] len32;
  logic [7:0]  byte_c;
  kind_e       kind_c;
  logic        eop_c;
  logic        seg_end;
  logic        goes_on;
  seg_e        next_seg;
  logic        done;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign produce   = busy_q && out_ready;
  assign len32     = 32'(cmd_q.length);

  // byte of the current segment at the current position
  always_comb begin
    byte_c   = 8'h00;
    kind_c   = KIND_HEADER;
    eop_c    = 1'b0;
    seg_end  = 1'b1;
    goes_on  = 1'b0;
    next_seg = SEG_TAIL;
    case (seg_q)
      SEG_HDR: begin
        kind_c  = KIND_HEADER;
        seg_end = pos_q == 3'd6;
        eop_c   = seg_end;
        goes_on = cmd_q.final_run;
        case (pos_q)
          3'd0:    byte_c = TYPE_HEADER;
          3'd1:    byte_c = len32[31:24];
          3'd2:    byte_c = len32[23:16];
          3'd3:    byte_c = len32[15:8];
          3'd4:    byte_c = len32[7:0];
          3'd5:    byte_c = cmd_q.number[15:8];
          default: byte_c = cmd_q.number[7:0];
        endcase
      end
      SEG_PRE: begin
        kind_c   = KIND_DATA;
        seg_end  = pos_q == 3'd2;
        goes_on  = 1'b1;
        next_seg = SEG_DAT;
        case (pos_q)
          3'd0:    byte_c = TYPE_DATA;
          3'd1:    byte_c = cmd_q.number[15:8];
          default: byte_c = cmd_q.number[7:0];
        endcase
      end
      SEG_DAT: begin
        kind_c  = KIND_DATA;
        byte_c  = cmd_q.data;
        eop_c   = cmd_q.eop;
        goes_on = cmd_q.final_run;
      end
      SEG_TAIL: begin
        kind_c  = KIND_TAIL;
        seg_end = pos_q == 3'd4;
        eop_c   = seg_end;
        case (pos_q)
          3'd0:    byte_c = TYPE_TAIL;
          3'd1:    byte_c = len32[31:24];
          3'd2:    byte_c = len32[23:16];
          3'd3:    byte_c = len32[15:8];
          default: byte_c = len32[7:0];
        endcase
      end
      default: begin
        seg_end = 1'b1;
        goes_on = 1'b0;
      end
    endcase
  end

  assign done   = seg_end && !goes_on;
  assign pop_o  = !empty_i && (!busy_q || (produce && done));
  assign busy_o = busy_q;

  // sequencer: step through segments, take the next command on the last byte
  always_comb begin
    busy_d = busy_q;
    seg_d  = seg_q;
    pos_d  = pos_q;
    cmd_d  = cmd_q;
    if (produce) begin
      if (!seg_end) begin
        pos_d = pos_q + 3'd1;
      end else if (goes_on) begin
        seg_d = next_seg;
        pos_d = '0;
      end else begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      cmd_d  = head_i;
      pos_d  = '0;
      if (head_i.is_start) begin
        seg_d = SEG_HDR;
      end else if (head_i.open_chunk) begin
        seg_d = SEG_PRE;
      end else begin
        seg_d = SEG_DAT;
      end
    end
  end

  // output register holds a result until it is taken
  assign out_valid_d = produce || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      seg_q       <= SEG_HDR;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      seg_q       <= seg_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (produce) begin
      out_byte_q <= byte_c;
      out_kind_q <= kind_c;
      out_eop_q  <= eop_c;
      out_last_q <= done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign packet_kind_o   = out_kind_q;
  assign end_of_packet_o = out_eop_q;
  assign last_of_run_o   = out_last_q;

endmodule

// File: rtl/image_chunk_packet_framer_unit.sv
// top level of the image chunk packet framer
`timescale 1ns / 1ps

// Splits an image byte stream into radio packet bytes.
// Input channel (in_valid_i / in_stall_o): a start request carries the image
// length and yields a 7-byte header packet (plus the 5-byte tail at once for a
// zero length); a data request carries one image byte, preceded by a 3-byte
// chunk preamble when it opens a chunk and followed by the tail after the
// final byte. Starts longer than the image limit and bytes outside an image
// are taken and dropped.
// Output channel (out_valid_o / out_stall_i): one packet byte per cycle while
// out_stall_i is low, with its packet kind, an end-of-packet mark and a mark
// on the last byte caused by a request.
// Requests enter a 4-entry command queue, one per cycle while it is not
// full; the back part sends one byte per cycle while the receiver does not
// stall, and a request yields from 1 byte (a plain data byte) up to 12.
// When the queue and the back part are idle, the first byte of a request
// passes the command queue, the back part's command register and the output
// register before it is valid.
// Receiver stall freezes the output register; the queue then fills and
// in_stall_o rises once it holds 4 commands.
// Reset clears the image state, the queue and the output valid.
module image_chunk_packet_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [16:0] image_length_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  packet_kind_o,
  output logic        end_of_packet_o,
  output logic        last_of_run_o
);
  import icpf_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic back_busy;
  cmd_t q_cmd;
  cmd_t q_head;

  // request classification
  icpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .action_i       (action_i),
    .image_length_i (image_length_i),
    .data_byte_i    (data_byte_i),
    .full_i         (q_full),
    .in_stall_o     (in_stall_o),
    .push_o         (q_push),
    .cmd_o          (q_cmd)
  );

  // command queue
  icpf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // packet byte generation
  icpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .empty_i         (q_empty),
    .pop_o           (q_pop),
    .busy_o          (back_busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .packet_kind_o   (packet_kind_o),
    .end_of_packet_o (end_of_packet_o),
    .last_of_run_o   (last_of_run_o)
  );

  // back part never takes from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("command taken from empty queue");

  // a command into an idle block shows its first byte after the queue, the command register and the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_empty && !back_busy && !out_valid_o) |-> ##3 out_valid_o)
    else $error("first byte of an idle request late");

  // the closing byte of a tail always ends the run of its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && packet_kind_o == KIND_TAIL && end_of_packet_o) |-> last_of_run_o)
    else $error("tail end without run end");

endmodule
